// ----- design/lss_pkg.sv -----
// Package for the LIFO stack with search: op, status, state and shift codes.
// Used by lss_cell, lss_chain and lifo_stack_with_search. No dependencies.
package lss_pkg;

    localparam int DEPTH_DEF     = 8;
    localparam int WORD_BITS_DEF = 32;

    // Field widths fixed by the stream format.
    localparam int FIELD_BITS  = 32;
    localparam int POS_BITS    = 3;
    localparam int FILL_BITS   = 4;
    localparam int IN_DATA_W   = 64;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 3;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_REPLACE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_DOWN = 2'd1,   // toward the bottom: push
        SH_UP   = 2'd2    // toward the top: pop or rotate
    } t_shift;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

endpackage

// ----- design/lifo_stack_with_search.sv -----
// Top level of the LIFO stack with search and replace.
// Depends on lss_pkg and lss_chain.
//
// Usage:
//   Input stream (s side): one word per operation. tuser carries the op
//   (push, pop, search, replace); tdata carries the value/key and the
//   replacement word. Output stream (m side): exactly one result word per
//   operation, in order: status and empty flag in tuser, and data, match
//   position and fill count in tdata.
// Timing:
//   Push and pop: the result is valid the cycle after accept.
//   Search and replace rotate the whole cell chain once past the top cell,
//   comparing each pushed entry there; the result is registered when the
//   rotation ends. One operation is in work at a time.
// Reset:
//   Synchronous active-low reset empties the stack (fill = 0) and drops any
//   pending result. Cell contents are not cleared; only pushed entries are
//   ever compared or returned.
// Back-pressure:
//   The result sits in an output register until taken. A new word is taken
//   while idle if that register is free or is being emptied the same cycle.
module lifo_stack_with_search #(
    parameter int DEPTH     = lss_pkg::DEPTH_DEF,
    parameter int WORD_BITS = lss_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lss_pkg::IN_DATA_W-1:0]   i_s_tdata,  // value[31:0], new_value[63:32]
    input  logic [lss_pkg::IN_USER_W-1:0]   i_s_tuser,  // mode[1:0]
    // master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [lss_pkg::OUT_DATA_W-1:0]  o_m_tdata,  // data[31:0], position[34:32],
                                                        // fill[38:35], zero[39]
    output logic [lss_pkg::OUT_USER_W-1:0]  o_m_tuser   // status[1:0], is_empty[2]
);

    localparam int CW   = $clog2(DEPTH + 1);             // fill count width
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1; // step counter width
    localparam int FW   = lss_pkg::FIELD_BITS;
    localparam logic [PW-1:0] LAST_STEP = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // ---------------- input decode ----------------
    lss_pkg::t_op         w_op;
    logic signed [FW-1:0] w_value;
    logic signed [FW-1:0] w_new_value;
    logic [WORD_BITS-1:0] w_key;
    logic [WORD_BITS-1:0] w_repl;
    logic                 w_accept;

    assign w_op        = lss_pkg::t_op'(i_s_tuser[1:0]);
    assign w_value     = i_s_tdata[FW-1:0];
    assign w_new_value = i_s_tdata[2*FW-1:FW];
    // sign-extend or truncate to the stored word width
    assign w_key       = WORD_BITS'(w_value);
    assign w_repl      = WORD_BITS'(w_new_value);

    // ---------------- control registers ----------------
    lss_pkg::t_state      r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [PW-1:0]        r_step,  n_step;
    logic [WORD_BITS-1:0] r_key;
    logic [WORD_BITS-1:0] r_repl;
    logic                 r_is_rep;
    logic                 r_found, n_found;
    logic [CW-1:0]        r_hpos,  n_hpos;
    logic [FW-1:0]        r_hdata, n_hdata;

    // output register
    logic                 r_ovalid, n_ovalid;
    lss_pkg::t_status     r_ostat,  n_ostat;
    logic [FW-1:0]        r_odata,  n_odata;
    logic [CW-1:0]        r_opos,   n_opos;
    logic [CW-1:0]        r_ofill,  n_ofill;

    // ---------------- cell chain ----------------
    lss_pkg::t_shift      w_shift;
    logic [WORD_BITS-1:0] w_top;
    logic [WORD_BITS-1:0] w_wrap;
    logic signed [WORD_BITS-1:0] w_top_s;
    logic [FW-1:0]        w_top_data;

    assign w_top_s    = w_top;
    assign w_top_data = FW'(w_top_s);

    lss_chain #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_shift     (w_shift),
        .i_push_word (w_key),
        .i_wrap_word (w_wrap),
        .o_top_word  (w_top)
    );

    // scan compare at the top cell: step j sees entry count-1-j
    logic          w_live;
    logic          w_hit;
    logic [CW-1:0] w_step_pos;

    assign w_live     = CW'(r_step) < r_count;
    assign w_hit      = w_live && !r_found && (w_top == r_key);
    assign w_step_pos = r_count - CW'(1) - CW'(r_step);
    assign w_wrap     = (w_hit && r_is_rep) ? r_repl : w_top;

    assign o_s_tready = (r_state == lss_pkg::ST_IDLE) && (!r_ovalid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_step   = r_step;
        n_found  = r_found;
        n_hpos   = r_hpos;
        n_hdata  = r_hdata;
        n_ovalid = r_ovalid && !i_m_tready;
        n_ostat  = r_ostat;
        n_odata  = r_odata;
        n_opos   = r_opos;
        n_ofill  = r_ofill;
        w_shift  = lss_pkg::SH_HOLD;

        case (r_state)
            lss_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_odata = '0;
                    n_opos  = '0;
                    n_ostat = lss_pkg::STS_OK;
                    case (w_op)
                        lss_pkg::OP_PUSH: begin
                            n_ovalid = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_ostat = lss_pkg::STS_FULL;
                            end else begin
                                w_shift = lss_pkg::SH_DOWN;
                                n_count = r_count + CW'(1);
                            end
                            n_ofill = n_count;
                        end
                        lss_pkg::OP_POP: begin
                            n_ovalid = 1'b1;
                            if (r_count == '0) begin
                                n_ostat = lss_pkg::STS_EMPTY;
                            end else begin
                                w_shift = lss_pkg::SH_UP;
                                n_count = r_count - CW'(1);
                                n_odata = w_top_data;
                            end
                            n_ofill = n_count;
                        end
                        default: begin
                            n_state = lss_pkg::ST_SCAN;
                            n_step  = '0;
                            n_found = 1'b0;
                            n_hpos  = '0;
                            n_hdata = '0;
                        end
                    endcase
                end
            end
            lss_pkg::ST_SCAN: begin
                // rotate the full ring so order is restored when the scan ends
                w_shift = lss_pkg::SH_UP;
                if (w_hit) begin
                    n_found = 1'b1;
                    n_hpos  = w_step_pos;
                    n_hdata = w_top_data;
                end
                if (r_step == LAST_STEP) begin
                    n_state  = lss_pkg::ST_IDLE;
                    n_ovalid = 1'b1;
                    n_ostat  = n_found ? lss_pkg::STS_OK : lss_pkg::STS_NOTFOUND;
                    n_odata  = n_hdata;
                    n_opos   = n_hpos;
                    n_ofill  = r_count;
                end else begin
                    n_step = r_step + PW'(1);
                end
            end
            default: begin
                n_state = lss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lss_pkg::ST_IDLE;
            r_count  <= '0;
            r_step   <= '0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_step   <= n_step;
            r_found  <= n_found;
            r_ovalid <= n_ovalid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key    <= w_key;
            r_repl   <= w_repl;
            r_is_rep <= (w_op == lss_pkg::OP_REPLACE);
        end
        r_hpos  <= n_hpos;
        r_hdata <= n_hdata;
        r_ostat <= n_ostat;
        r_odata <= n_odata;
        r_opos  <= n_opos;
        r_ofill <= n_ofill;
    end

    // ---------------- output packing ----------------
    logic [CW+lss_pkg::POS_BITS-1:0]  w_pos_ext;
    logic [CW+lss_pkg::FILL_BITS-1:0] w_fill_ext;

    assign w_pos_ext  = (CW + lss_pkg::POS_BITS)'(r_opos);
    assign w_fill_ext = (CW + lss_pkg::FILL_BITS)'(r_ofill);

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, w_fill_ext[lss_pkg::FILL_BITS-1:0],
                         w_pos_ext[lss_pkg::POS_BITS-1:0], r_odata};
    assign o_m_tuser  = {(r_ofill == '0), r_ostat};

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count above depth");

    a_step_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lss_pkg::ST_SCAN && r_step != LAST_STEP)
        |=> (r_state == lss_pkg::ST_SCAN && r_step == $past(r_step) + PW'(1)))
        else $error("scan step did not advance");

    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lss_pkg::ST_SCAN && r_step == LAST_STEP)
        |=> (r_ovalid && r_state == lss_pkg::ST_IDLE))
        else $error("scan end without result");

    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == lss_pkg::OP_PUSH && r_count != FULL_CNT)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow fill count");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lss_pkg::ST_SCAN) |=> $stable(r_count))
        else $error("fill count changed during scan");

endmodule

// ----- design/lss_cell.sv -----
// One stack cell: a single stored word that holds or takes a neighbor's word.
// Depends on lss_pkg.
module lss_cell #(
    parameter int WORD_BITS = lss_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  lss_pkg::t_shift      i_shift,
    input  logic [WORD_BITS-1:0] i_from_above,
    input  logic [WORD_BITS-1:0] i_from_below,
    output logic [WORD_BITS-1:0] o_word
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        case (i_shift)
            lss_pkg::SH_DOWN: n_word = i_from_above;
            lss_pkg::SH_UP:   n_word = i_from_below;
            default:          n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- design/lss_chain.sv -----
// Row of lss_cell instances; cell 0 is the top of the stack.
// Depends on lss_pkg and lss_cell.
module lss_chain #(
    parameter int DEPTH     = lss_pkg::DEPTH_DEF,
    parameter int WORD_BITS = lss_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  lss_pkg::t_shift      i_shift,
    input  logic [WORD_BITS-1:0] i_push_word,
    input  logic [WORD_BITS-1:0] i_wrap_word,
    output logic [WORD_BITS-1:0] o_top_word
);

    logic [WORD_BITS-1:0] w_words [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_BITS-1:0] w_above;
        logic [WORD_BITS-1:0] w_below;

        if (i == 0) begin : g_top
            assign w_above = i_push_word;
        end else begin : g_mid
            assign w_above = w_words[i-1];
        end

        // bottom cell closes the ring for rotation
        if (i == DEPTH - 1) begin : g_bot
            assign w_below = i_wrap_word;
        end else begin : g_up
            assign w_below = w_words[i+1];
        end

        lss_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_shift      (i_shift),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_word       (w_words[i])
        );
    end

    assign o_top_word = w_words[0];

endmodule

// ----- sim/lss_stack_checker.sv -----
// Checker for lifo_stack_with_search: watches both stream channels, keeps its own
// copy of the stack, and compares every result word with the expected one.
// Depends on lss_pkg for op and status codes and for the stream widths.
module lss_stack_checker #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [lss_pkg::IN_DATA_W-1:0]   i_s_tdata,  // value[31:0], new_value[63:32]
    input  logic [lss_pkg::IN_USER_W-1:0]   i_s_tuser,  // mode[1:0]
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [lss_pkg::OUT_DATA_W-1:0]  i_m_tdata,  // data[31:0], position[34:32],
                                                        // fill[38:35], zero[39]
    input  logic [lss_pkg::OUT_USER_W-1:0]  i_m_tuser,  // status[1:0], is_empty[2]
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        lss_pkg::t_status status;
        logic [31:0]      data;
        logic [2:0]       position;
        logic [3:0]       fill;
        logic             is_empty;
    } t_stack_result;

    logic [31:0]   slots [DEPTH];
    int            depth_used = 0;
    t_stack_result results_due [$];
    int            failures = 0;

    assign o_fail_count = failures;

    // Applies one op to the shadow stack and returns the result it should give.
    // Search and replace take the topmost equal entry, so the last hit wins.
    function automatic t_stack_result apply_stack_op(input lss_pkg::t_op op,
                                                     input logic [31:0] value,
                                                     input logic [31:0] new_value);
        t_stack_result r;
        int            hit;
        r        = '0;
        r.status = lss_pkg::STS_OK;
        hit      = -1;
        case (op)
            lss_pkg::OP_PUSH: begin
                if (depth_used >= DEPTH) begin
                    r.status = lss_pkg::STS_FULL;
                end else begin
                    slots[depth_used] = value;
                    depth_used++;
                end
            end
            lss_pkg::OP_POP: begin
                if (depth_used == 0) begin
                    r.status = lss_pkg::STS_EMPTY;
                end else begin
                    depth_used--;
                    r.data = slots[depth_used];
                end
            end
            default: begin
                for (int i = 0; i < depth_used; i++)
                    if (slots[i] == value)
                        hit = i;
                if (hit < 0) begin
                    r.status = lss_pkg::STS_NOTFOUND;
                end else begin
                    r.data     = slots[hit];
                    r.position = 3'(hit);
                    if (op == lss_pkg::OP_REPLACE)
                        slots[hit] = new_value;
                end
            end
        endcase
        r.fill     = 4'(depth_used);
        r.is_empty = (depth_used == 0);
        return r;
    endfunction

    // Result side first: a word accepted this edge cannot answer an op taken
    // at the same edge.
    always @(posedge i_clk) begin
        t_stack_result seen;
        t_stack_result due;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                seen.status   = lss_pkg::t_status'(i_m_tuser[1:0]);
                seen.is_empty = i_m_tuser[2];
                seen.data     = i_m_tdata[31:0];
                seen.position = i_m_tdata[34:32];
                seen.fill     = i_m_tdata[38:35];
                if (results_due.size() == 0) begin
                    if (failures < REPORT_LIMIT)
                        $display({"%0t: result word with none due: ",
                                  "status %0d data %h pos %0d fill %0d empty %0b"},
                                 $realtime, seen.status, seen.data, seen.position,
                                 seen.fill, seen.is_empty);
                    failures <= failures + 1;
                end else begin
                    due = results_due.pop_front();
                    if (seen !== due || i_m_tdata[39] !== 1'b0) begin
                        if (failures < REPORT_LIMIT) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    exp: status %0d data %h pos %0d fill %0d empty %0b pad 0",
                                     due.status, due.data, due.position, due.fill,
                                     due.is_empty);
                            $display("    got: status %0d data %h pos %0d fill %0d empty %0b pad %b",
                                     seen.status, seen.data, seen.position, seen.fill,
                                     seen.is_empty, i_m_tdata[39]);
                        end
                        failures <= failures + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(apply_stack_op(lss_pkg::t_op'(i_s_tuser),
                                                     i_s_tdata[31:0], i_s_tdata[63:32]));
            o_pending <= results_due.size();
        end
    end

endmodule

// ----- sim/lifo_stack_with_search_tb.sv -----
// Testbench top for lifo_stack_with_search: reset, directed and random op words,
// sender bursts and receiver stalls, and the final verdict.
// Depends on lss_pkg, lifo_stack_with_search and lss_stack_checker.
module lifo_stack_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = lss_pkg::DEPTH_DEF;
    localparam int RANDOM_WORDS = 1950;
    // Slowest legal run: ~1980 words, each a full scan plus the longest receiver
    // stall and sender gap, stays well under this limit.
    localparam int CYCLE_LIMIT  = 400000;
    // Quiet time after the last result; covers a full scan and a sink stall.
    localparam int TAIL_CYCLES  = 8 * DEPTH;

    // Receiver stall patterns, switched at random intervals.
    typedef enum logic [1:0] {
        SINK_OPEN,        // always ready
        SINK_COIN,        // ready half the time, at random
        SINK_ONE_IN_FOUR, // ready one cycle in four
        SINK_LONG_STALL   // a stalled stretch, then a ready stretch, repeating
    } t_sink_kind;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [lss_pkg::IN_DATA_W-1:0]   i_s_tdata;   // value[31:0], new_value[63:32]
    logic [lss_pkg::IN_USER_W-1:0]   i_s_tuser;   // mode[1:0]
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [lss_pkg::OUT_DATA_W-1:0]  o_m_tdata;   // data[31:0], position[34:32],
                                                  // fill[38:35], zero[39]
    logic [lss_pkg::OUT_USER_W-1:0]  o_m_tuser;   // status[1:0], is_empty[2]

    int fail_count;
    int pending;
    int cycle_count = 0;

    // sender burst state
    int burst_left = 0;

    // receiver pattern state
    t_sink_kind sink_kind = SINK_OPEN;
    int         sink_left = 0;
    int         sink_tick = 0;

    // Keys that repeat, so searches hit and the stack holds duplicates.
    logic [31:0] key_pool [6];

    // Directed fill: extremes, zero, all ones, and a duplicate of the max.
    logic [31:0] fill_words [8] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h5A5A_5A5A, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h0000_0001
    };

    lifo_stack_with_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    lss_stack_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the block hangs or a result never shows up.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lifo_stack_with_search verification failed");
            $finish;
        end
    end

    // Receiver: a new stall pattern after each random stretch; open stretches
    // come up about a quarter of the time.
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_kind <= t_sink_kind'($urandom_range(0, 3));
            sink_left <= $urandom_range(20, 200);
        end else begin
            sink_left <= sink_left - 1;
        end
        sink_tick <= sink_tick + 1;
        case (sink_kind)
            SINK_OPEN:        i_m_tready <= 1'b1;
            SINK_COIN:        i_m_tready <= 1'($urandom_range(0, 1));
            SINK_ONE_IN_FOUR: i_m_tready <= (sink_tick % 4 == 0);
            default:          i_m_tready <= (sink_tick % 13 >= 9);
        endcase
    end

    // Mostly pool keys so search and replace find matches, some extremes,
    // and some fully random words that toggle every bit.
    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return key_pool[$urandom_range(0, 5)];
        else if (roll == 6)
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        else
            return $urandom;
    endfunction

    // Sends one op word and returns right after the edge that takes it.
    // Burst gaps are inserted before the word, so valid is only ever
    // lowered in a step where nothing else drives it.
    task automatic send_word(input lss_pkg::t_op op, input logic [31:0] value,
                             input logic [31:0] new_value);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {new_value, value};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Sender holds off until every result due has been taken. The extra
    // edge lets the checker count the word taken last.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        lss_pkg::t_op op;
        int           push_bias;
        int           roll;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= lss_pkg::OP_PUSH;
        for (int i = 0; i < 6; i++)
            key_pool[i] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // empty stack: pop, search and replace all miss
        send_word(lss_pkg::OP_POP,     32'h0000_0000, 32'h0000_0000);
        send_word(lss_pkg::OP_SEARCH,  32'h0000_0000, 32'h0000_0000);
        send_word(lss_pkg::OP_REPLACE, 32'hFFFF_FFFF, 32'h1234_5678);
        // fill to the top, then one push too many
        for (int i = 0; i < 8; i++)
            send_word(lss_pkg::OP_PUSH, fill_words[i], ~fill_words[i]);
        send_word(lss_pkg::OP_PUSH, 32'h1234_5678, 32'hFFFF_FFFF);
        // duplicate key: the upper copy wins; then bottom and top slots; then a miss
        send_word(lss_pkg::OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(lss_pkg::OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
        send_word(lss_pkg::OP_SEARCH, 32'h0000_0001, 32'h0000_0000);
        send_word(lss_pkg::OP_SEARCH, 32'hDEAD_BEEF, 32'h0000_0000);
        // replace the upper duplicate; the next search lands on the lower one
        send_word(lss_pkg::OP_REPLACE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(lss_pkg::OP_SEARCH,  32'h7FFF_FFFF, 32'h0000_0000);
        send_word(lss_pkg::OP_REPLACE, 32'hCAFE_F00D, 32'h0000_0000);
        // unwind to empty, then pop once more
        for (int i = 0; i < 9; i++)
            send_word(lss_pkg::OP_POP, 32'h0000_0000, 32'hFFFF_FFFF);
        drain_results();

        // --- random ---
        // push_bias changes every 64 words so the fill wanders between
        // empty and full instead of sitting in the middle.
        push_bias = 40;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 64 == 0) begin
                push_bias = $urandom_range(20, 60);
                key_pool[$urandom_range(0, 5)] = $urandom;
            end
            if (n == RANDOM_WORDS / 2)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < push_bias)
                op = lss_pkg::OP_PUSH;
            else
                case ($urandom_range(0, 2))
                    0:       op = lss_pkg::OP_POP;
                    1:       op = lss_pkg::OP_SEARCH;
                    default: op = lss_pkg::OP_REPLACE;
                endcase
            send_word(op, pick_word(), $urandom);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("lifo_stack_with_search verification clean");
        else
            $display("lifo_stack_with_search verification failed");
        $finish;
    end

endmodule
